### hdl/twtl_pkg.sv
// Package for the time window trade log.
// Holds function and status codes, the item and result types, symbol helper.
package twtl_pkg;

    localparam int TimeW  = 32;
    localparam int SymW   = 40;
    localparam int PriceW = 32;
    localparam int QtyW   = 32;
    localparam int WindowReset = 60000;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [TimeW-1:0]  trade_time;
        logic [SymW-1:0]   symbol;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   quantity;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] total_qty;
        logic [31:0] high_all;
        logic [31:0] low_all;
        logic [31:0] sym_high;
        logic [31:0] sym_low;
        logic [31:0] sym_avg;
    } result_t;

    // Symbol ends at its first zero byte; later bytes read as zero.
    function automatic logic [SymW-1:0] canon_symbol(input logic [SymW-1:0] s);
        logic [SymW-1:0] r;
        logic            live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 5; b++) begin
            if (s[8*b +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*b +: 8] = s[8*b +: 8];
        end
        return r;
    endfunction

endpackage

### hdl/twtl_if.sv
// Valid/ready channel interfaces for the trade log.
// Depends on twtl_pkg for the payload types.
interface twtl_item_if import twtl_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface twtl_result_if import twtl_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/twtl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module twtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hdl/twtl_div.sv
// Restoring divider, one quotient bit per cycle, for the symbol mean.
// Depends on nothing; 64-bit dividend over a count divisor.
module twtl_div #(
    parameter int NW = 64,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    assign trial = {rem_reg[DW-1:0], quo_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

### hdl/time_window_trade_log_unit.sv
// Top level of the time window trade log: sequencer, ring RAM, scan unit.
// Depends on twtl_pkg, twtl_if, twtl_ram and twtl_div.
//
// Usage: items arrive on in_ch (valid/ready), one result beat per item
// leaves on out_ch. window_ms is written through cfg_we/cfg_data; it is to
// be written only while idle, which the block itself does not enforce.
// Per item, unless the window is above latest_time or the log is empty,
// the sequencer first walks the oldest end of the ring, one entry per pass
// (RAM read, then compare), dropping entries older than latest_time -
// window_ms. A valid add with room then writes one slot.
// A query on a non-empty log walks all live entries through the RAM read
// port and then runs the bit-serial divider for the symbol mean.
// A new item is accepted only after the previous result has been taken.
// in_ch.ready is high only in the idle state with no result pending.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its idle state with ready low.
// Reset: log empty, latest_time 0, window 60000; RAM contents are not
// cleared (only live entries are ever read).
module time_window_trade_log_unit
    import twtl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    twtl_item_if.sink              in_ch,
    twtl_result_if.source          out_ch,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = TimeW + SymW + PriceW + QtyW;

    typedef enum logic [2:0] {
        S_IDLE, S_EV_RD, S_EV_CMP, S_DISPATCH, S_Q_RD, S_Q_ACC, S_DIV, S_DIV_WAIT
    } state_t;

    state_t         state_reg;
    logic [31:0]    window_reg;
    logic [AW-1:0]  oldest_reg;
    logic [CW-1:0]  count_reg;
    logic [31:0]    latest_reg;
    item_t          item_reg;
    logic [CW-1:0]  idx_reg;
    logic [31:0]    tq_reg, hi_reg, lo_reg, shi_reg, slo_reg;
    logic [63:0]    sum_reg;
    logic [CW-1:0]  n_reg;
    logic           any_reg;
    result_t        res_reg;
    logic           res_valid_reg;

    // ring storage: one RAM holding the packed entry
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [RW-1:0]  ram_wdata, ram_rdata;
    logic [AW:0]    rd_sum;
    logic [AW:0]    wr_sum;

    twtl_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [TimeW-1:0]  e_time;
    logic [SymW-1:0]   e_sym;
    logic [PriceW-1:0] e_price;
    logic [QtyW-1:0]   e_qty;
    assign {e_time, e_sym, e_price, e_qty} = ram_rdata;

    // read address: oldest + offset, write address: oldest + count, both wrapped
    always_comb
    begin
        rd_sum = {1'b0, oldest_reg} + (AW+1)'(idx_reg);
        if (rd_sum >= (AW+1)'(CAPACITY)) rd_sum = rd_sum - (AW+1)'(CAPACITY);
        wr_sum = {1'b0, oldest_reg} + (AW+1)'(count_reg);
        if (wr_sum >= (AW+1)'(CAPACITY)) wr_sum = wr_sum - (AW+1)'(CAPACITY);
    end
    assign ram_raddr = rd_sum[AW-1:0];
    assign ram_waddr = wr_sum[AW-1:0];
    assign ram_wdata = {item_reg.trade_time, canon_symbol(item_reg.symbol),
                        item_reg.price, item_reg.quantity};

    logic add_bad, add_ok;
    assign add_bad = (item_reg.price == '0) || (item_reg.quantity == '0)
                  || (item_reg.trade_time < latest_reg);
    assign add_ok  = (state_reg == S_DISPATCH) && (item_reg.func == FUNC_ADD)
                  && !add_bad && (count_reg != CW'(CAPACITY));
    assign ram_we  = add_ok;

    logic [31:0] limit;
    assign limit = latest_reg - window_reg;

    logic sym_hit;
    assign sym_hit = (e_sym == canon_symbol(item_reg.symbol));

    // mean divider
    logic        div_start, div_busy;
    logic [63:0] div_q;
    assign div_start = (state_reg == S_DIV);
    twtl_div #(.NW(64), .DW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_reg),
        .divisor(n_reg), .busy(div_busy), .quotient(div_q)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= 32'(WindowReset);
            oldest_reg    <= '0;
            count_reg     <= '0;
            latest_reg    <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we) window_reg <= cfg_data;
            if (out_ch.valid && out_ch.ready) res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg <= in_ch.data;
                        idx_reg  <= '0;
                        state_reg <= (window_reg > latest_reg || count_reg == '0)
                                     ? S_DISPATCH : S_EV_RD;
                    end
                end
                // eviction: read oldest entry, then compare
                S_EV_RD: state_reg <= S_EV_CMP;
                S_EV_CMP:
                begin
                    if (e_time < limit)
                    begin
                        oldest_reg <= (oldest_reg == AW'(CAPACITY - 1))
                                      ? '0 : oldest_reg + 1'b1;
                        count_reg  <= count_reg - 1'b1;
                        state_reg  <= (count_reg == CW'(1)) ? S_DISPATCH : S_EV_RD;
                    end
                    else state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    res_reg <= '0;
                    tq_reg <= '0; hi_reg <= '0; lo_reg <= '0;
                    shi_reg <= '0; slo_reg <= '0; sum_reg <= '0;
                    n_reg <= '0; any_reg <= 1'b0; idx_reg <= '0;
                    state_reg <= S_IDLE;
                    case (item_reg.func)
                        FUNC_ADD:
                        begin
                            if (add_bad) res_reg.status <= ST_INVALID;
                            else if (count_reg == CW'(CAPACITY))
                                res_reg.status <= ST_FULL;
                            else
                            begin
                                count_reg  <= count_reg + 1'b1;
                                latest_reg <= item_reg.trade_time;
                            end
                            res_valid_reg <= 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            if (count_reg == '0) res_valid_reg <= 1'b1;
                            else state_reg <= S_Q_RD;
                        end
                        FUNC_CLEAR:
                        begin
                            count_reg <= '0; oldest_reg <= '0; latest_reg <= '0;
                            res_valid_reg <= 1'b1;
                        end
                        default: res_valid_reg <= 1'b1;
                    endcase
                end
                S_Q_RD: state_reg <= S_Q_ACC;
                // query: fold one entry per pass
                S_Q_ACC:
                begin
                    tq_reg  <= tq_reg + e_qty;
                    if (!any_reg || e_price > hi_reg) hi_reg <= e_price;
                    if (!any_reg || e_price < lo_reg) lo_reg <= e_price;
                    any_reg <= 1'b1;
                    if (sym_hit)
                    begin
                        if (n_reg == '0 || e_price > shi_reg) shi_reg <= e_price;
                        if (n_reg == '0 || e_price < slo_reg) slo_reg <= e_price;
                        sum_reg <= sum_reg + 64'(e_price);
                        n_reg   <= n_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == count_reg) ? S_DIV : S_Q_RD;
                end
                S_DIV:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (!div_busy)
                    begin
                        res_reg.status    <= ST_DONE;
                        res_reg.total_qty <= tq_reg;
                        res_reg.high_all  <= hi_reg;
                        res_reg.low_all   <= lo_reg;
                        res_reg.sym_high  <= shi_reg;
                        res_reg.sym_low   <= slo_reg;
                        res_reg.sym_avg   <= (n_reg == '0) ? '0 : div_q[31:0];
                        res_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)) else $error("entry count over capacity");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == S_IDLE && !out_ch.valid))
        else $error("ready outside idle");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> count_reg < CW'(CAPACITY)) else $error("write into full ring");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> state_reg == S_IDLE)
        else $error("work while result pending");
endmodule

### tb/time_window_trade_log_unit_test.sv
// Testbench for the time window trade log: drives trade, query and clear beats
// and checks every result against an in-bench model of the ring. Needs twtl_pkg, twtl_if and the unit top.
module time_window_trade_log_unit_test;
    import twtl_pkg::*;

    localparam int Depth = 64;
    localparam int IdleLimit = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_data;

    twtl_item_if   in_ch();
    twtl_result_if out_ch();

    time_window_trade_log_unit #(.CAPACITY(Depth)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // model state
    logic [31:0] mdl_window;
    logic [31:0] ring_time [Depth];
    logic [39:0] ring_sym [Depth];
    logic [31:0] ring_price [Depth];
    logic [31:0] ring_qty [Depth];
    int unsigned ring_head;
    int unsigned ring_count;
    logic [31:0] newest_time;

    result_t expected_results[$];
    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int quiet_cycles;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [39:0] trim_symbol(logic [39:0] s);
        logic [39:0] r;
        bit live;
        r = '0;
        live = 1'b1;
        for (int b = 0; b < 5; b++)
        begin
            if (s[8*b +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*b +: 8] = s[8*b +: 8];
        end
        return r;
    endfunction

    // Apply one item to the ring model and return its result.
    function automatic result_t log_step(item_t it);
        result_t r;
        logic [39:0] sym;
        logic [31:0] lim;
        logic [63:0] sum;
        int unsigned n, k;
        bit any;
        r = '0;
        sym = trim_symbol(it.symbol);
        if (mdl_window <= newest_time)
        begin
            lim = newest_time - mdl_window;
            while (ring_count > 0 && ring_time[ring_head] < lim)
            begin
                ring_head = (ring_head + 1) % Depth;
                ring_count--;
            end
        end
        case (func_t'(it.func))
            FUNC_ADD:
            begin
                if (it.price == 0 || it.quantity == 0 || it.trade_time < newest_time)
                    r.status = ST_INVALID;
                else if (ring_count >= Depth)
                    r.status = ST_FULL;
                else
                begin
                    k = (ring_head + ring_count) % Depth;
                    ring_time[k] = it.trade_time;
                    ring_sym[k] = sym;
                    ring_price[k] = it.price;
                    ring_qty[k] = it.quantity;
                    ring_count++;
                    newest_time = it.trade_time;
                end
            end
            FUNC_QUERY:
            begin
                n = 0;
                sum = 0;
                any = 0;
                for (int i = 0; i < ring_count; i++)
                begin
                    k = (ring_head + i) % Depth;
                    r.total_qty += ring_qty[k];
                    if (!any || ring_price[k] > r.high_all) r.high_all = ring_price[k];
                    if (!any || ring_price[k] < r.low_all) r.low_all = ring_price[k];
                    any = 1;
                    if (ring_sym[k] == sym)
                    begin
                        if (n == 0 || ring_price[k] > r.sym_high) r.sym_high = ring_price[k];
                        if (n == 0 || ring_price[k] < r.sym_low) r.sym_low = ring_price[k];
                        sum += ring_price[k];
                        n++;
                    end
                end
                if (n > 0) r.sym_avg = 32'(sum / n);
            end
            FUNC_CLEAR:
            begin
                ring_count = 0;
                ring_head = 0;
                newest_time = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one beat; the model is updated at acceptance. valid stays high
    // after acceptance until the next idle gap or drain.
    task automatic send_item(item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (!in_ch.ready);
        expected_results.push_back(log_step(it));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_window(logic [31:0] w);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_window = w;
    endtask

    function automatic item_t make_item(logic [1:0] f, logic [31:0] t, logic [39:0] s,
                                        logic [31:0] p, logic [31:0] q);
        item_t it;
        it.func = f;
        it.trade_time = t;
        it.symbol = s;
        it.price = p;
        it.quantity = q;
        return it;
    endfunction

    function automatic logic [39:0] pick_symbol();
        case ($urandom_range(5))
            0: return 40'h4142;
            1: return 40'h43;
            2: return 40'h44_4300_4142;   // bytes after a zero are ignored
            3: return {$urandom(), 8'($urandom())};
            default: return 40'h58_5859_5a5a;
        endcase
    endfunction

    // Special cases, extremes and every function code.
    task automatic test_directed();
        send_item(make_item(FUNC_QUERY, 0, 40'h4142, 0, 0));
        send_item(make_item(FUNC_ADD, 100, 40'h4142, 0, 5));
        send_item(make_item(FUNC_ADD, 100, 40'h4142, 5, 0));
        send_item(make_item(FUNC_ADD, 100, 40'hff_ff00_4142, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_item(FUNC_ADD, 100, 40'h4142, 1, 32'hffff_ffff));
        send_item(make_item(FUNC_ADD, 99, 40'h4142, 7, 7));
        send_item(make_item(FUNC_QUERY, 0, 40'h4142, 0, 0));
        send_item(make_item(FUNC_QUERY, 0, 40'hff_ffff_ffff, 0, 0));
        send_item(make_item(FUNC_NOP, 32'hffff_ffff, 40'hff_ffff_ffff,
                            32'hffff_ffff, 32'hffff_ffff));
        send_item(make_item(FUNC_ADD, 32'hffff_ffff, 40'hff_ffff_ffff, 3, 3));
        send_item(make_item(FUNC_QUERY, 0, 40'hff_ffff_ffff, 0, 0));
        send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
        send_item(make_item(FUNC_QUERY, 0, 40'h4142, 0, 0));
        // fill to the limit, then one more
        for (int i = 0; i <= Depth; i++)
            send_item(make_item(FUNC_ADD, 10, 40'h43, 32'(i + 1), 2));
        send_item(make_item(FUNC_QUERY, 0, 40'h43, 0, 0));
        send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
    endtask

    // Random sequences of non-decreasing times with queries, clears and noise mixed in.
    task automatic test_random(int count, logic [31:0] step_max);
        item_t it;
        logic [31:0] t;
        t = newest_time;
        for (int i = 0; i < count; i++)
        begin
            it = make_item(2'($urandom()), $urandom(), {$urandom(), 8'($urandom())},
                           $urandom(), $urandom());
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                begin
                    t = t + $urandom_range(step_max);
                    it = make_item(FUNC_ADD, t, pick_symbol(), $urandom_range(1000) + 1,
                                   $urandom_range(500) + 1);
                    if ($urandom_range(9) == 0) it.price = $urandom();
                end
                10, 11, 12, 13, 14, 15:
                    it = make_item(FUNC_QUERY, $urandom(), pick_symbol(), $urandom(), $urandom());
                16:
                    if ($urandom_range(3) == 0) it.func = FUNC_CLEAR;
                    else it.func = FUNC_NOP;
                default: ;  // noise
            endcase
            send_item(it);
            if (it.func == FUNC_CLEAR) t = 0;
            else t = newest_time;
        end
    endtask

    // Receiver stalls long while the sender keeps offering.
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                recv_hold = 1'b0;
            end
            test_random(20, 50);
        join
        drain();
    endtask

    // checker: one beat at a time against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", out_ch.data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_ch.data.status !== exp_r.status
                    || out_ch.data.total_qty !== exp_r.total_qty
                    || out_ch.data.high_all !== exp_r.high_all
                    || out_ch.data.low_all !== exp_r.low_all
                    || out_ch.data.sym_high !== exp_r.sym_high
                    || out_ch.data.sym_low !== exp_r.sym_low
                    || out_ch.data.sym_avg !== exp_r.sym_avg)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h actual %h", exp_r, out_ch.data);
                end
            end
        end
    end

    // receiver ready
    always @(posedge clk)
    begin
        if (recv_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IdleLimit && !timed_out)
        begin
            timed_out = 1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        recv_hold = 1'b0;
        quiet_cycles = 0;
        timed_out = 0;
        mismatch_count = 0;
        mdl_window = WindowReset;
        ring_head = 0;
        ring_count = 0;
        newest_time = 0;
        send_idle_pct = 15;
        recv_idle_pct = 78;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250, 2000);
        write_window(0);
        test_random(150, 3);
        write_window(32'hffff_ffff);
        send_idle_pct = 78;
        recv_idle_pct = 15;
        test_random(300, 32'h0100_0000);
        write_window(50);
        test_random(300, 20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        write_window(500);
        test_random(450, 30);
        write_window(WindowReset);
        send_item(make_item(FUNC_QUERY, 0, 40'h43, 0, 0));

        drain();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
